FILE: hw/rtl/smcs_pkg.sv
// Shared types, register indexes and mode codes for the stereo mic channel selector.
package smcs_pkg;

    // Store capacity in frames
    localparam int MAX_FRAMES = 64;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 7;
    localparam int ENERGY_W = 37;
    localparam int HOLD_W   = 17;

    // Shared multiplier operand widths and product width
    localparam int MUL_A_W = ENERGY_W;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_INPUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_Q8   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEAK_RATIO   = 3'd4;

    // Register reset values
    localparam logic        RST_STEREO_INPUT = 1'b1;
    localparam logic [1:0]  RST_CHANNEL_MODE = 2'd0;
    localparam logic [15:0] RST_HOLD_MIN     = 16'd6000;
    localparam logic [23:0] RST_SILENCE_Q8   = 24'd86924;
    localparam logic [16:0] RST_WEAK_RATIO   = 17'd4135;

    // Requested channel mode
    localparam logic [1:0] REQ_AUTO  = 2'd0;
    localparam logic [1:0] REQ_LEFT  = 2'd1;
    localparam logic [1:0] REQ_RIGHT = 2'd2;
    localparam logic [1:0] REQ_AVG   = 2'd3;

    // Selected mode reported with each word
    localparam logic [1:0] SEL_LEFT  = 2'd0;
    localparam logic [1:0] SEL_RIGHT = 2'd1;
    localparam logic [1:0] SEL_AVG   = 2'd2;
    localparam logic [1:0] SEL_MONO  = 2'd3;

    // Held side of a one-sided decision
    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_LEFT  = 2'd1;
    localparam logic [1:0] HELD_RIGHT = 2'd2;

    // Input frame word
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_left;
        logic signed [SAMPLE_W-1:0] sample_right;
        logic                       block_end;
    } t_in;

    // Result word
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mono_sample;
        logic [1:0]                 selected_mode;
        logic                       one_sided;
        logic                       rejected;
        logic [SAMPLE_W-1:0]        left_peak;
        logic [SAMPLE_W-1:0]        right_peak;
        logic [COUNT_W-1:0]         frames_in_block;
        logic                       last_out;
    } t_out;

endpackage

FILE: hw/rtl/smcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module smcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/stereo_mic_channel_selector_unit.sv
// Top level of the stereo mic channel selector: frame store, shared multiplier and sequencer.
//
// The block takes one block of int16 frames, stores it, and then emits one mono word per
// frame, with the mode chosen at block end (auto energy compare with hold, fixed manual mode,
// or mono passthrough). Each stored frame passes the accept step plus three steps, while the
// one shared 37x24 multiplier squares the left and right magnitudes and the squares go into
// the energy accumulators. In auto stereo mode the block end adds decision steps on the same
// multiplier (floor times frame count, then the two ratio products). Each result word then
// passes the store read address, registered read data and output register handshake steps,
// plus any stall from the receiver. A block longer than MAX_FRAMES frames gives one rejected
// word. The input is stalled from the accept of a frame until its work is done, and from the
// block end until its last word is taken.
module stereo_mic_channel_selector_unit #(
    parameter int MAX_FRAMES = smcs_pkg::MAX_FRAMES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  smcs_pkg::t_in                      i_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output smcs_pkg::t_out                     o_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [smcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [smcs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int SW     = smcs_pkg::SAMPLE_W;
    localparam int CW     = smcs_pkg::COUNT_W;
    localparam int EW     = smcs_pkg::ENERGY_W;
    localparam int HW     = smcs_pkg::HOLD_W;
    localparam int AWID   = smcs_pkg::MUL_A_W;
    localparam int BWID   = smcs_pkg::MUL_B_W;
    localparam int PW     = smcs_pkg::PROD_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ_L  = 4'd1;
    localparam logic [3:0] S_SQ_R  = 4'd2;
    localparam logic [3:0] S_ACC_R = 4'd3;
    localparam logic [3:0] S_FLOOR = 4'd4;
    localparam logic [3:0] S_LW    = 4'd5;
    localparam logic [3:0] S_RW    = 4'd6;
    localparam logic [3:0] S_DEC   = 4'd7;
    localparam logic [3:0] S_RD    = 4'd8;
    localparam logic [3:0] S_LD    = 4'd9;
    localparam logic [3:0] S_WAIT  = 4'd10;
    localparam logic [3:0] S_REJ   = 4'd11;

    // Configuration registers
    logic        r_stereo;
    logic [1:0]  r_req_mode;
    logic [15:0] r_hold_min;
    logic [23:0] r_floor_q8;
    logic [16:0] r_weak_q16;

    // Control and accumulation state
    logic [3:0]    r_state;
    logic [3:0]    n_state;
    logic [EW-1:0] r_lenergy;
    logic [EW-1:0] r_renergy;
    logic [SW-1:0] r_lmax;
    logic [SW-1:0] r_rmax;
    logic [CW-1:0] r_count;
    logic [1:0]    r_held;
    logic [HW-1:0] r_hold_rem;
    logic          r_end;
    logic [SW-1:0] r_rmag;
    logic [CW-1:0] r_idx;
    logic          r_lact;
    logic          r_ract;
    logic          r_lone;
    logic [1:0]    r_sel;
    logic          r_onesided;
    logic          r_ovalid;
    smcs_pkg::t_out r_out;

    // Shared multiplier
    logic [AWID-1:0] mul_a;
    logic [BWID-1:0] mul_b;
    logic [PW-1:0]   r_prod;

    // Store
    logic [2*SW-1:0] ram_rdata;
    logic            accept_in;
    logic            accept_out;
    logic            store_full;

    // Per-frame and decision logic
    logic [SW-1:0]   mag_l;
    logic [SW-1:0]   mag_r;
    logic [HW-1:0]   n_ext;
    logic [HW-1:0]   hold_len;
    logic            rone;
    logic signed [SW-1:0] fl;
    logic signed [SW-1:0] fr;
    logic signed [SW:0]   pair_sum;
    logic signed [SW:0]   avg_wide;
    logic signed [SW-1:0] mono_val;
    logic                 is_last;

    assign accept_in   = i_valid && !o_stall;
    assign accept_out  = r_ovalid && !i_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;
    assign store_full  = (r_count >= CW'(MAX_FRAMES));

    // Magnitudes of the incoming samples
    assign mag_l = i_data.sample_left[SW-1]  ? SW'(-i_data.sample_left)  : SW'(i_data.sample_left);
    assign mag_r = i_data.sample_right[SW-1] ? SW'(-i_data.sample_right) : SW'(i_data.sample_right);

    // Hold length after a one-sided decision
    assign n_ext    = HW'(r_count);
    assign hold_len = (n_ext > HW'(r_hold_min)) ? n_ext : HW'(r_hold_min);

    // Right one-sided test, product holds right energy times weak ratio
    assign rone = r_ract && (PW'({r_lenergy, 16'b0}) <= r_prod);

    // Mono sample from the stored frame
    assign fl       = ram_rdata[SW-1:0];
    assign fr       = ram_rdata[2*SW-1:SW];
    assign pair_sum = (SW+1)'(fl) + (SW+1)'(fr);
    assign avg_wide = (pair_sum + (SW+1)'(pair_sum[SW])) >>> 1;
    assign is_last  = ((r_idx + CW'(1)) == r_count);

    always_comb begin
        unique case (r_sel)
            smcs_pkg::SEL_LEFT:  mono_val = fl;
            smcs_pkg::SEL_RIGHT: mono_val = fr;
            smcs_pkg::SEL_AVG:   mono_val = avg_wide[SW-1:0];
            smcs_pkg::SEL_MONO:  mono_val = fl;
        endcase
    end

    // Frame store
    smcs_ram #(
        .WIDTH (2 * SW),
        .DEPTH (MAX_FRAMES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept_in && !store_full),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_data.sample_right, i_data.sample_left}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Select multiplier operands for the current step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_IDLE: begin
                mul_a = AWID'(mag_l);
                mul_b = BWID'(mag_l);
            end
            S_SQ_L: begin
                mul_a = AWID'(r_rmag);
                mul_b = BWID'(r_rmag);
            end
            S_FLOOR: begin
                mul_a = AWID'(r_floor_q8);
                mul_b = BWID'(r_count);
            end
            S_LW: begin
                mul_a = r_lenergy;
                mul_b = BWID'(r_weak_q16);
            end
            S_RW: begin
                mul_a = r_renergy;
                mul_b = BWID'(r_weak_q16);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(mul_a) * PW'(mul_b);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    if (store_full) begin
                        n_state = i_data.block_end ? S_REJ : S_IDLE;
                    end else begin
                        n_state = S_SQ_L;
                    end
                end
            end
            S_SQ_L:  n_state = S_SQ_R;
            S_SQ_R:  n_state = S_ACC_R;
            S_ACC_R: begin
                if (!r_end) begin
                    n_state = S_IDLE;
                end else if (r_stereo && (r_req_mode == smcs_pkg::REQ_AUTO)) begin
                    n_state = S_FLOOR;
                end else begin
                    n_state = S_RD;
                end
            end
            S_FLOOR: n_state = S_LW;
            S_LW:    n_state = S_RW;
            S_RW:    n_state = S_DEC;
            S_DEC:   n_state = S_RD;
            S_RD:    n_state = S_LD;
            S_LD:    n_state = S_WAIT;
            S_REJ:   n_state = S_WAIT;
            S_WAIT: begin
                if (accept_out) begin
                    n_state = r_out.last_out ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stereo   <= smcs_pkg::RST_STEREO_INPUT;
            r_req_mode <= smcs_pkg::RST_CHANNEL_MODE;
            r_hold_min <= smcs_pkg::RST_HOLD_MIN;
            r_floor_q8 <= smcs_pkg::RST_SILENCE_Q8;
            r_weak_q16 <= smcs_pkg::RST_WEAK_RATIO;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                smcs_pkg::CFG_STEREO_INPUT: r_stereo   <= i_cfg_data[0];
                smcs_pkg::CFG_CHANNEL_MODE: r_req_mode <= i_cfg_data[1:0];
                smcs_pkg::CFG_HOLD_MIN:     r_hold_min <= i_cfg_data[15:0];
                smcs_pkg::CFG_SILENCE_Q8:   r_floor_q8 <= i_cfg_data[23:0];
                smcs_pkg::CFG_WEAK_RATIO:   r_weak_q16 <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Sequencer, accumulators, decision and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_lenergy  <= '0;
            r_renergy  <= '0;
            r_lmax     <= '0;
            r_rmax     <= '0;
            r_count    <= '0;
            r_held     <= smcs_pkg::HELD_NONE;
            r_hold_rem <= '0;
            r_ovalid   <= 1'b0;
            r_idx      <= '0;
            r_end      <= 1'b0;
            r_sel      <= smcs_pkg::SEL_AVG;
            r_onesided <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                // Take a frame: store, track peaks, start squaring left; drop it once full
                S_IDLE: begin
                    if (accept_in) begin
                        r_end <= i_data.block_end;
                        r_idx <= '0;
                        if (!store_full) begin
                            r_rmag  <= mag_r;
                            r_count <= r_count + CW'(1);
                            if (mag_l > r_lmax) begin
                                r_lmax <= mag_l;
                            end
                            if (mag_r > r_rmax) begin
                                r_rmax <= mag_r;
                            end
                        end
                    end
                end
                S_SQ_L: begin
                    r_lenergy <= r_lenergy + r_prod[EW-1:0];
                end
                S_SQ_R: begin
                    r_renergy <= r_renergy + r_prod[EW-1:0];
                end
                // Block end without the auto compare: mono or manual mode
                S_ACC_R: begin
                    r_onesided <= 1'b0;
                    if (r_end) begin
                        if (!r_stereo) begin
                            r_sel      <= smcs_pkg::SEL_MONO;
                            r_held     <= smcs_pkg::HELD_NONE;
                            r_hold_rem <= '0;
                        end else if (r_req_mode != smcs_pkg::REQ_AUTO) begin
                            r_held     <= smcs_pkg::HELD_NONE;
                            r_hold_rem <= '0;
                            unique case (r_req_mode)
                                smcs_pkg::REQ_LEFT:  r_sel <= smcs_pkg::SEL_LEFT;
                                smcs_pkg::REQ_RIGHT: r_sel <= smcs_pkg::SEL_RIGHT;
                                smcs_pkg::REQ_AVG:   r_sel <= smcs_pkg::SEL_AVG;
                                smcs_pkg::REQ_AUTO:  r_sel <= smcs_pkg::SEL_AVG;
                            endcase
                        end
                    end
                end
                S_FLOOR: ;
                // Activity tests against floor times frame count
                S_LW: begin
                    r_lact <= (PW'({r_lenergy, 8'b0}) >= r_prod);
                    r_ract <= (PW'({r_renergy, 8'b0}) >= r_prod);
                end
                // Left one-sided test against left energy times weak ratio
                S_RW: begin
                    r_lone <= r_lact && (PW'({r_renergy, 16'b0}) <= r_prod);
                end
                // Decide the mode and update the hold
                S_DEC: begin
                    if (r_lone) begin
                        r_held     <= smcs_pkg::HELD_LEFT;
                        r_hold_rem <= hold_len;
                        r_onesided <= 1'b1;
                        r_sel      <= smcs_pkg::SEL_LEFT;
                    end else if (rone) begin
                        r_held     <= smcs_pkg::HELD_RIGHT;
                        r_hold_rem <= hold_len;
                        r_onesided <= 1'b1;
                        r_sel      <= smcs_pkg::SEL_RIGHT;
                    end else if (!r_lact && !r_ract && (r_hold_rem != '0)
                                 && (r_held == smcs_pkg::HELD_LEFT
                                     || r_held == smcs_pkg::HELD_RIGHT)) begin
                        r_hold_rem <= (r_hold_rem > n_ext) ? (r_hold_rem - n_ext) : '0;
                        r_sel      <= (r_held == smcs_pkg::HELD_LEFT) ?
                                      smcs_pkg::SEL_LEFT : smcs_pkg::SEL_RIGHT;
                    end else begin
                        r_held     <= smcs_pkg::HELD_NONE;
                        r_hold_rem <= '0;
                        r_sel      <= smcs_pkg::SEL_AVG;
                    end
                end
                S_RD: ;
                // Load the next result word from the store read data
                S_LD: begin
                    r_ovalid                <= 1'b1;
                    r_out.mono_sample       <= mono_val;
                    r_out.selected_mode     <= r_sel;
                    r_out.one_sided         <= r_onesided;
                    r_out.rejected          <= 1'b0;
                    r_out.left_peak         <= r_lmax;
                    r_out.right_peak        <= (r_sel == smcs_pkg::SEL_MONO) ? r_lmax : r_rmax;
                    r_out.frames_in_block   <= r_count;
                    r_out.last_out          <= is_last;
                end
                // Oversize block: one flagged word, hold state untouched
                S_REJ: begin
                    r_ovalid                <= 1'b1;
                    r_out.mono_sample       <= '0;
                    r_out.selected_mode     <= smcs_pkg::SEL_LEFT;
                    r_out.one_sided         <= 1'b0;
                    r_out.rejected          <= 1'b1;
                    r_out.left_peak         <= '0;
                    r_out.right_peak        <= '0;
                    r_out.frames_in_block   <= '0;
                    r_out.last_out          <= 1'b1;
                end
                // Hand off the word; advance or close the block
                S_WAIT: begin
                    if (accept_out) begin
                        r_ovalid <= 1'b0;
                        r_idx    <= r_idx + CW'(1);
                        if (r_out.last_out) begin
                            r_lenergy <= '0;
                            r_renergy <= '0;
                            r_lmax    <= '0;
                            r_rmax    <= '0;
                            r_count   <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
